// ===== rtl/core/kgsr_pkg.sv =====
// Shared types and constants for the k-group stream reverser.
// No dependencies; used by every module in rtl/core.
`default_nettype none
package kgsr_pkg;

    localparam int MAX_GROUP_DEF = 16;   // default group buffer depth
    localparam int VALUE_W       = 32;   // payload width
    localparam int GSIZE_W       = 5;    // group_size register width
    localparam logic [GSIZE_W-1:0] GSIZE_RST = GSIZE_W'(2);
    localparam int CMDQ_DEPTH    = 2;    // burst command queue depth

    // What the back end does with a closed group
    typedef struct packed {
        logic rev;   // emit newest first
        logic fin;   // group closed by list end
    } cmd_flags_t;

    localparam int CMD_FLAGS_W = $bits(cmd_flags_t);

    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/k_group_stream_reverser_core.sv =====
// Values arrive one beat per cycle while s_tready is high and are held until
// group_size of them have come in (or s_tlast ends the list); the group then
// leaves as a burst of one beat per cycle while m_tready is high, newest first
// for a full group, arrival order for a short group closed by list end. While
// a burst is queued or draining, intake is held off, since the single group
// buffer is being read: a group is taken in, then drained, with a hand-over
// between (command pop, intake release), so no new value is taken until the
// burst has read its last entry. The first beat of a burst passes through the
// command queue, the sequencer's burst state and the output register before
// it is on m_tvalid. m_tlast marks the last beat of each burst, m_tuser marks
// the final beat of the list. group_size 0 behaves as 1, values above
// MAX_GROUP saturate; write cfg only while the block is idle.
// Depends on kgsr_pkg, kgsr_front, kgsr_cmd_fifo and kgsr_back.
`default_nettype none
module k_group_stream_reverser_core #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wen,
    input  wire logic [kgsr_pkg::GSIZE_W-1:0] cfg_wdata,   // group_size
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [kgsr_pkg::VALUE_W-1:0] s_tdata,     // [31:0] value
    input  wire logic                         s_tlast,     // list_end
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [kgsr_pkg::VALUE_W-1:0]      m_tdata,     // [31:0] value_out
    output logic                              m_tlast,     // run_last
    output logic                              m_tuser      // [0] list_last
);

    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CMD_W  = CNT_W + kgsr_pkg::CMD_FLAGS_W;

    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [kgsr_pkg::VALUE_W-1:0] wr_data;
    logic                         fcmd_valid, fcmd_ready;
    logic [CNT_W-1:0]             fcmd_count, bcmd_count;
    kgsr_pkg::cmd_flags_t         fcmd_flags, bcmd_flags;
    logic                         bcmd_valid, bcmd_pop;
    logic [CMD_W-1:0]             q_in, q_out;
    logic                         back_busy;

    assign q_in       = {fcmd_count, fcmd_flags};
    assign bcmd_count = q_out[CMD_W-1:kgsr_pkg::CMD_FLAGS_W];
    assign bcmd_flags = kgsr_pkg::cmd_flags_t'(q_out[kgsr_pkg::CMD_FLAGS_W-1:0]);

    kgsr_front #(
        .MAX_GROUP (MAX_GROUP),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .cmd_valid  (fcmd_valid),
        .cmd_ready  (fcmd_ready),
        .cmd_count  (fcmd_count),
        .cmd_flags  (fcmd_flags),
        .cmdq_empty (!bcmd_valid),
        .back_busy  (back_busy)
    );

    kgsr_cmd_fifo #(
        .DATA_W (CMD_W)
    ) u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fcmd_valid),
        .push_ready (fcmd_ready),
        .push_data  (q_in),
        .pop        (bcmd_pop),
        .pop_valid  (bcmd_valid),
        .pop_data   (q_out)
    );

    kgsr_back #(
        .MAX_GROUP (MAX_GROUP),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .cmd_valid (bcmd_valid),
        .cmd_pop   (bcmd_pop),
        .cmd_count (bcmd_count),
        .cmd_flags (bcmd_flags),
        .busy      (back_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/core/kgsr_front.sv =====
// Intake side: group_size register, fill count, buffer writes and group closing.
// Depends on kgsr_pkg.
`default_nettype none
module kgsr_front #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
    parameter int CNT_W     = $clog2(MAX_GROUP + 1),
    parameter int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wen,
    input  wire logic [kgsr_pkg::GSIZE_W-1:0]      cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [kgsr_pkg::VALUE_W-1:0]      s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   wr_en,
    output logic [ADDR_W-1:0]                      wr_addr,
    output logic [kgsr_pkg::VALUE_W-1:0]           wr_data,
    output logic                                   cmd_valid,
    input  wire logic                              cmd_ready,
    output logic [CNT_W-1:0]                       cmd_count,
    output kgsr_pkg::cmd_flags_t                   cmd_flags,
    input  wire logic                              cmdq_empty,
    input  wire logic                              back_busy
);

    localparam int SZ_W = (CNT_W > kgsr_pkg::GSIZE_W) ? CNT_W : kgsr_pkg::GSIZE_W;

    logic [kgsr_pkg::GSIZE_W-1:0] gsize_reg;
    logic [CNT_W-1:0]             fill_reg, fill_next;
    logic                         hold_reg, hold_next;
    logic [SZ_W-1:0]              gs_ext, eff_size, n_held;
    logic                         accept, full_grp, close_grp;

    // effective size: zero means pass-through, saturate at buffer depth
    always_comb begin
        gs_ext = SZ_W'(gsize_reg);
        priority if (gsize_reg == '0) begin
            eff_size = SZ_W'(1);
        end else if (gs_ext > SZ_W'(MAX_GROUP)) begin
            eff_size = SZ_W'(MAX_GROUP);
        end else begin
            eff_size = gs_ext;
        end
    end

    assign s_tready  = !hold_reg && cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign n_held    = SZ_W'(fill_reg) + SZ_W'(1);
    assign full_grp  = (n_held >= eff_size);
    assign close_grp = full_grp || s_tlast;

    assign wr_en   = accept;
    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = s_tdata;

    assign cmd_valid     = accept && close_grp;
    assign cmd_count     = CNT_W'(n_held);
    assign cmd_flags.rev = full_grp;
    assign cmd_flags.fin = s_tlast;

    always_comb begin
        fill_next = fill_reg;
        hold_next = hold_reg;
        if (accept) begin
            if (close_grp) begin
                fill_next = '0;
                hold_next = 1'b1;
            end else begin
                fill_next = CNT_W'(n_held);
            end
        end else if (hold_reg && cmdq_empty && !back_busy) begin
            // burst has read its last entry, buffer free again
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gsize_reg <= kgsr_pkg::GSIZE_RST;
            fill_reg  <= '0;
            hold_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                gsize_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            hold_reg <= hold_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/kgsr_cmd_fifo.sv =====
// Short command queue between intake and burst sides.
// Depends on kgsr_pkg.
`default_nettype none
module kgsr_cmd_fifo #(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic                   pop_valid,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int DEPTH = kgsr_pkg::CMDQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/kgsr_back.sv =====
// Burst side: group buffer memory and the sequencer that drains it to the output.
// Depends on kgsr_pkg.
`default_nettype none
module kgsr_back #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
    parameter int CNT_W     = $clog2(MAX_GROUP + 1),
    parameter int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [kgsr_pkg::VALUE_W-1:0] wr_data,
    input  wire logic                         cmd_valid,
    output logic                              cmd_pop,
    input  wire logic [CNT_W-1:0]             cmd_count,
    input  wire kgsr_pkg::cmd_flags_t         cmd_flags,
    output logic                              busy,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [kgsr_pkg::VALUE_W-1:0]      m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    logic [kgsr_pkg::VALUE_W-1:0] mem [MAX_GROUP];

    kgsr_pkg::back_state_t state_reg, state_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    kgsr_pkg::cmd_flags_t  flags_reg, flags_next;
    logic                  mvalid_reg, mvalid_next;
    logic                  rlast_reg, llast_reg;
    logic [kgsr_pkg::VALUE_W-1:0] rdata_reg;
    logic                  issue, final_beat;

    // during a burst, read straight into the output register whenever it is free or draining
    assign issue      = (state_reg == kgsr_pkg::BK_BURST) && (!mvalid_reg || m_tready);
    assign final_beat = (left_reg == CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kgsr_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    state_next = kgsr_pkg::BK_BURST;
                end
            end
            kgsr_pkg::BK_BURST: begin
                if (issue && final_beat) begin
                    state_next = kgsr_pkg::BK_IDLE;
                end
            end
            default: state_next = kgsr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop     = 1'b0;
        left_next   = left_reg;
        addr_next   = addr_reg;
        flags_next  = flags_reg;
        mvalid_next = mvalid_reg && !m_tready;
        unique case (state_reg)
            kgsr_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    left_next  = cmd_count;
                    flags_next = cmd_flags;
                    addr_next  = cmd_flags.rev ? ADDR_W'(cmd_count - 1'b1) : '0;
                end
            end
            kgsr_pkg::BK_BURST: begin
                if (issue) begin
                    mvalid_next = 1'b1;
                    left_next   = left_reg - 1'b1;
                    addr_next   = flags_reg.rev ? addr_reg - 1'b1 : addr_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign busy     = (state_reg == kgsr_pkg::BK_BURST);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tlast  = rlast_reg;
    assign m_tuser  = llast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= kgsr_pkg::BK_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        addr_reg  <= addr_next;
        flags_reg <= flags_next;
        if (issue) begin
            rdata_reg <= mem[addr_reg];
            rlast_reg <= final_beat;
            llast_reg <= final_beat && flags_reg.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== tb/kgsr_order_checker.sv =====
// Checker for k_group_stream_reverser_core: watches the cfg port and both streams,
// predicts the reordered output beats and compares them field by field.
// Depends on kgsr_pkg.
module kgsr_order_checker
    import kgsr_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic [GSIZE_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [VALUE_W-1:0] m_tdata,
    input  logic               m_tlast,
    input  logic               m_tuser,
    output int                 fail_count,
    output int                 outstanding,
    output int                 values_in,
    output int                 values_out
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               run_last;
        logic               list_last;
    } reordered_beat_t;

    reordered_beat_t    reordered_q[$];
    logic [VALUE_W-1:0] held_values [MAX_GROUP];
    int unsigned        held_count;
    logic [GSIZE_W-1:0] group_size;
    int                 errs  = 0;
    int                 n_in  = 0;
    int                 n_out = 0;

    function automatic int unsigned group_limit(input logic [GSIZE_W-1:0] gs);
        if (gs == '0)
            return 1;
        if (gs > MAX_GROUP)
            return MAX_GROUP;
        return gs;
    endfunction

    // Hold one value; once the group closes, queue its burst (newest first when full).
    function automatic void fold_in_value(input logic [VALUE_W-1:0] v, input logic ends);
        int unsigned     lim;
        int unsigned     n;
        reordered_beat_t b;
        lim = group_limit(group_size);
        if (held_count < MAX_GROUP) begin
            held_values[held_count] = v;
            held_count++;
        end
        n = held_count;
        if (n >= lim || ends) begin
            for (int unsigned i = 0; i < n; i++) begin
                b.value     = (n >= lim) ? held_values[n - 1 - i] : held_values[i];
                b.run_last  = (i + 1 == n);
                b.list_last = b.run_last && ends;
                reordered_q.push_back(b);
            end
            held_count = 0;
        end
    endfunction

    always @(posedge aclk) begin
        reordered_beat_t want;
        if (!aresetn) begin
            held_count = 0;
            group_size = GSIZE_RST;
            reordered_q.delete();
        end else begin
            // an output beat can never stem from an input taken at the same edge
            if (m_tvalid && m_tready) begin
                n_out++;
                if (reordered_q.size() == 0) begin
                    $error("value_out: expected no beat, got %0d", $signed(m_tdata));
                    errs++;
                end else begin
                    want = reordered_q.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("value_out: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata));
                        errs++;
                    end
                    if (m_tlast !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, m_tlast);
                        errs++;
                    end
                    if (m_tuser !== want.list_last) begin
                        $error("list_last: expected %0b, got %0b", want.list_last, m_tuser);
                        errs++;
                    end
                end
            end
            if (cfg_wen)
                group_size = cfg_wdata;
            if (s_tvalid && s_tready) begin
                n_in++;
                fold_in_value(s_tdata, s_tlast);
            end
        end
        outstanding <= reordered_q.size();
        fail_count  <= errs;
        values_in   <= n_in;
        values_out  <= n_out;
    end

endmodule

// ===== tb/tb_k_group_stream_reverser_core.sv =====
// Testbench top for k_group_stream_reverser_core: clock, reset, cfg writes and
// stream stimulus with random stalls; the verdict comes from kgsr_order_checker.
// Depends on kgsr_pkg, kgsr_order_checker and the core RTL.
module tb_k_group_stream_reverser_core;
    import kgsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 135;
    localparam int CALM_ITEMS   = 30;
    localparam int SETTLE       = 8;    // extra idle cycles before a cfg write
    localparam int CHOKE_CYCLES = 120;
    localparam int DRAIN_CYCLES = 20;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wen;
    logic [GSIZE_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;     // [31:0] value
    logic               s_tlast;     // list_end
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;     // [31:0] value_out
    logic               m_tlast;     // run_last
    logic               m_tuser;     // [0] list_last

    int fail_count;
    int outstanding;
    int values_in;
    int values_out;
    int items_sent;
    int cfg_writes;
    int src_gap_odds;                 // 0: no gaps, else one beat in (odds+1) gets one
    int sink_gap_odds;
    bit calm;
    bit choke_req;

    k_group_stream_reverser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    kgsr_order_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .values_in   (values_in),
        .values_out  (values_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for output beats");
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_beat(input logic [VALUE_W-1:0] v, input logic ends);
        s_tdata  <= v;
        s_tlast  <= ends;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (!calm && src_gap_odds != 0 && $urandom_range(0, src_gap_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_list(input int len, input bit closes);
        for (int i = 0; i < len; i++)
            push_beat(pick_value(), closes && (i == len - 1));
    endtask

    // cfg only once every expected beat is out and the back end has settled
    task automatic write_group_size(input logic [GSIZE_W-1:0] gs);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wdata <= gs;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        cfg_writes++;
    endtask

    // sink: random stall bursts, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (choke_req) begin
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge aclk);
                choke_req = 1'b0;
            end else if (!calm && sink_gap_odds != 0 && $urandom_range(0, sink_gap_odds) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int          phase;
        int          lists;
        int          eff;
        int          len;
        int          target;
        logic [GSIZE_W-1:0] gs;
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        items_sent    = 0;
        cfg_writes    = 0;
        src_gap_odds  = 3;
        sink_gap_odds = 3;
        calm          = 1'b0;
        choke_req     = 1'b0;
        phase         = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset group size of two: full pair, short list, full pair closing the list
        push_beat(32'h7FFF_FFFF, 1'b0);
        push_beat(32'h8000_0000, 1'b0);
        push_beat(32'h0000_0000, 1'b1);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h0000_0001, 1'b1);
        // straight through, and zero behaving as one
        write_group_size(GSIZE_W'(1));
        send_list(2, 1'b1);
        write_group_size(GSIZE_W'(0));
        push_beat(32'h8000_0000, 1'b0);
        // size lowered while two values are held: next beat flushes all three
        write_group_size(GSIZE_W'(3));
        send_list(2, 1'b0);
        write_group_size(GSIZE_W'(2));
        push_beat(32'h7FFF_FFFF, 1'b0);
        // all-ones size saturates to the buffer depth
        write_group_size('1);
        send_list(MAX_GROUP_DEF, 1'b0);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            phase++;
            case ($urandom_range(0, 9))
                0: gs = '0;
                1: gs = GSIZE_W'(MAX_GROUP_DEF);
                2: gs = GSIZE_W'($urandom_range(MAX_GROUP_DEF + 1, 31));
                3: gs = '1;
                default: gs = GSIZE_W'($urandom_range(1, 6));
            endcase
            if (phase == 3)
                gs = GSIZE_W'(4);
            write_group_size(gs);
            eff = (gs == 0) ? 1 : ((gs > MAX_GROUP_DEF) ? MAX_GROUP_DEF : int'(gs));
            src_gap_odds  = $urandom_range(0, 4);
            sink_gap_odds = $urandom_range(0, 4);
            if (phase == 3)
                choke_req = 1'b1;   // sender keeps offering while the sink holds off
            lists = (phase == 3) ? 6 : $urandom_range(1, 3);
            for (int l = 0; l < lists; l++) begin
                len = $urandom_range(1, (eff > 6) ? eff + 4 : 3 * eff);
                // a phase may end mid-group, so the next size applies to held values
                send_list(len, (l < lists - 1) || ($urandom_range(0, 4) != 0));
                calm = (items_sent >= target - CALM_ITEMS);
            end
        end
        push_beat(pick_value(), 1'b1);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d input beats and %0d output beats under %0d group_size writes,",
                 values_in, values_out, cfg_writes);
        $display("incl. saturated and zero sizes, size changes mid-group and a long sink stall.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
